// ===== hw/rtl/spt_pkg.sv =====
package spt_pkg;

  // table geometry
  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = ADDR_W + 1;
  localparam int FRAC_BITS = 16;
  localparam int VAL_W    = 32;

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_BAD_INDEX = 2'd3;

  // extreme Q16.16 values for the bound trackers
  localparam logic signed [VAL_W-1:0] VAL_MOST_POS = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MOST_NEG = {1'b1, {(VAL_W-1){1'b0}}};

  // one stored entry
  typedef struct packed {
    logic signed [VAL_W-1:0] x;
    logic signed [VAL_W-1:0] y;
  } pair_t;

  // running bounds of everything inserted
  typedef struct packed {
    logic signed [VAL_W-1:0] min_x;
    logic signed [VAL_W-1:0] max_x;
    logic signed [VAL_W-1:0] min_y;
    logic signed [VAL_W-1:0] max_y;
  } bounds_t;

endpackage

// ===== hw/rtl/spt_bounds.sv =====
module spt_bounds (
  input  logic           clk,
  input  logic           rst,
  input  logic           upd,
  input  spt_pkg::pair_t new_pair,
  output spt_pkg::bounds_t bnd
);

  spt_pkg::bounds_t bnd_next;

  // widen each bound toward the new pair
  always_comb begin
    bnd_next = bnd;
    if (new_pair.x < bnd.min_x) bnd_next.min_x = new_pair.x;
    if (bnd.max_x < new_pair.x) bnd_next.max_x = new_pair.x;
    if (new_pair.y < bnd.min_y) bnd_next.min_y = new_pair.y;
    if (bnd.max_y < new_pair.y) bnd_next.max_y = new_pair.y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bnd.min_x <= spt_pkg::VAL_MOST_POS;
      bnd.max_x <= spt_pkg::VAL_MOST_NEG;
      bnd.min_y <= spt_pkg::VAL_MOST_POS;
      bnd.max_y <= spt_pkg::VAL_MOST_NEG;
    end else if (upd) begin
      bnd <= bnd_next;
    end
  end

endmodule

// ===== hw/rtl/sorted_pair_table_floor_lookup_core.sv =====
// channel   | signals                                         | timing
// ----------+-------------------------------------------------+---------------------------
// command   | start, busy, cmd, key_x, val_y, entry_index     | taken when start & !busy
// result    | done, status, found_index, found_x, found_y,    | one cycle, done strobe
//           | entry_count, min_x, max_x, min_y, max_y         | receiver cannot stall
//
// Entries live in one 64-bit synchronous RAM, x beside y, with a read and a write port.
// Insert walks down, one shift a cycle, moving up each entry whose x is not below the key.
// Floor lookup walks up from entry 0 until the key is passed; a key below min_x or at
// or above max_x and a read by index read one entry directly; errors read none.
// Synchronous reset empties the table at once and restores the bounds; no clearing pass.
// busy stays high for the whole walk; a new word may start in the cycle done is high.
module sorted_pair_table_floor_lookup_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [1:0]                       cmd,
  input  logic signed [spt_pkg::VAL_W-1:0] key_x,
  input  logic signed [spt_pkg::VAL_W-1:0] val_y,
  input  logic [spt_pkg::ADDR_W-1:0]       entry_index,
  output logic                             busy,
  output logic                             done,
  output logic [1:0]                       status,
  output logic [spt_pkg::ADDR_W-1:0]       found_index,
  output logic signed [spt_pkg::VAL_W-1:0] found_x,
  output logic signed [spt_pkg::VAL_W-1:0] found_y,
  output logic [spt_pkg::CNT_W-1:0]        entry_count,
  output logic signed [spt_pkg::VAL_W-1:0] min_x,
  output logic signed [spt_pkg::VAL_W-1:0] max_x,
  output logic signed [spt_pkg::VAL_W-1:0] min_y,
  output logic signed [spt_pkg::VAL_W-1:0] max_y
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_LOOK = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_PUT  = 3'd4;

  logic [2:0]                     state;
  logic [spt_pkg::CNT_W-1:0]      used_count;
  logic [spt_pkg::ADDR_W-1:0]     paddr;
  logic [spt_pkg::ADDR_W-1:0]     pos;
  logic signed [spt_pkg::VAL_W-1:0] kx;
  logic signed [spt_pkg::VAL_W-1:0] vy;
  spt_pkg::pair_t                 prev;
  spt_pkg::pair_t                 new_pair;
  spt_pkg::bounds_t               bnd;

  // entry memory
  spt_pkg::pair_t                 mem [spt_pkg::CAPACITY];
  spt_pkg::pair_t                 rd_pair;
  spt_pkg::pair_t                 wdata;
  logic [spt_pkg::ADDR_W-1:0]     raddr;
  logic [spt_pkg::ADDR_W-1:0]     waddr;
  logic                           wen;

  logic [spt_pkg::ADDR_W-1:0]     cnt_m1;
  logic [spt_pkg::ADDR_W-1:0]     tgt;
  logic                           key_lt_lo;
  logic                           key_ge_hi;
  logic                           rd_lt_kx;
  logic                           put_upd;

  assign busy        = (state != S_IDLE);
  assign entry_count = used_count;
  assign min_x       = bnd.min_x;
  assign max_x       = bnd.max_x;
  assign min_y       = bnd.min_y;
  assign max_y       = bnd.max_y;

  assign new_pair.x = kx;
  assign new_pair.y = vy;
  assign put_upd    = (state == S_PUT);

  spt_bounds u_bounds (
    .clk      (clk),
    .rst      (rst),
    .upd      (put_upd),
    .new_pair (new_pair),
    .bnd      (bnd)
  );

  // first address to read when a word is taken
  assign cnt_m1    = used_count[spt_pkg::ADDR_W-1:0] - 1'b1;
  assign key_lt_lo = key_x < bnd.min_x;
  assign key_ge_hi = !(key_x < bnd.max_x);
  assign rd_lt_kx  = rd_pair.x < kx;

  always_comb begin
    case (cmd)
      spt_pkg::CMD_INSERT: tgt = cnt_m1;
      spt_pkg::CMD_LOOKUP: tgt = (!key_lt_lo && key_ge_hi) ? cnt_m1 : '0;
      spt_pkg::CMD_READ:   tgt = entry_index;
      default:             tgt = '0;
    endcase
  end

  // read address: walk down for insert, up for lookup
  always_comb begin
    case (state)
      S_INS:   raddr = paddr - 1'b1;
      S_LOOK:  raddr = paddr + 1'b1;
      default: raddr = tgt;
    endcase
  end

  // write port: shift during insert walk, new pair at the end
  always_comb begin
    wen   = 1'b0;
    waddr = paddr + 1'b1;
    wdata = rd_pair;
    if (state == S_INS && !rd_lt_kx) begin
      wen = 1'b1;
    end else if (state == S_PUT) begin
      wen   = 1'b1;
      waddr = pos;
      wdata = new_pair;
    end
  end

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rd_pair <= mem[raddr];
  end

  // command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      used_count <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            kx          <= key_x;
            vy          <= val_y;
            status      <= spt_pkg::ST_OK;
            found_index <= '0;
            found_x     <= '0;
            found_y     <= '0;
            case (cmd)
              spt_pkg::CMD_INSERT: begin
                if (used_count == spt_pkg::CNT_W'(spt_pkg::CAPACITY)) begin
                  status <= spt_pkg::ST_FULL;
                  done   <= 1'b1;
                end else if (used_count == '0) begin
                  pos   <= '0;
                  state <= S_PUT;
                end else begin
                  paddr <= tgt;
                  state <= S_INS;
                end
              end
              spt_pkg::CMD_LOOKUP: begin
                if (used_count == '0) begin
                  status <= spt_pkg::ST_EMPTY;
                  done   <= 1'b1;
                end else if (key_lt_lo || key_ge_hi) begin
                  paddr <= tgt;
                  state <= S_RD;
                end else begin
                  paddr <= '0;
                  state <= S_LOOK;
                end
              end
              spt_pkg::CMD_READ: begin
                if (used_count == '0) begin
                  status <= spt_pkg::ST_EMPTY;
                  done   <= 1'b1;
                end else if ({1'b0, entry_index} >= used_count) begin
                  status <= spt_pkg::ST_BAD_INDEX;
                  done   <= 1'b1;
                end else begin
                  paddr <= tgt;
                  state <= S_RD;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        // rd_pair holds entry paddr; stop at the first x below the key
        S_INS: begin
          if (rd_lt_kx) begin
            pos   <= paddr + 1'b1;
            state <= S_PUT;
          end else if (paddr == '0) begin
            pos   <= '0;
            state <= S_PUT;
          end else begin
            paddr <= paddr - 1'b1;
          end
        end
        // rd_pair holds entry paddr; the entry before the first x above the key wins
        S_LOOK: begin
          if (paddr != '0 && kx < rd_pair.x) begin
            found_index <= paddr - 1'b1;
            found_x     <= prev.x;
            found_y     <= prev.y;
            done        <= 1'b1;
            state       <= S_IDLE;
          end else begin
            prev  <= rd_pair;
            paddr <= paddr + 1'b1;
          end
        end
        S_RD: begin
          found_index <= paddr;
          found_x     <= rd_pair.x;
          found_y     <= rd_pair.y;
          done        <= 1'b1;
          state       <= S_IDLE;
        end
        S_PUT: begin
          found_index <= pos;
          found_x     <= kx;
          found_y     <= vy;
          used_count  <= used_count + 1'b1;
          done        <= 1'b1;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== dv/sorted_pair_table_floor_lookup_core_test.sv =====
`timescale 1ns / 1ps

module sorted_pair_table_floor_lookup_core_test;
  import spt_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 1550;
  localparam int DRAIN_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  // handy Q16.16 values
  localparam logic signed [VAL_W-1:0] Q_ZERO = 32'sh0000_0000;
  localparam logic signed [VAL_W-1:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [VAL_W-1:0] Q_TWO = 32'sh0002_0000;
  localparam logic signed [VAL_W-1:0] Q_THREE = 32'sh0003_0000;
  localparam logic signed [VAL_W-1:0] Q_MINUS = 32'shFFFF_FFFF;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [VAL_W-1:0] kx;
    logic signed [VAL_W-1:0] vy;
    logic [ADDR_W-1:0]       idx;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [ADDR_W-1:0]       index;
    logic signed [VAL_W-1:0] x;
    logic signed [VAL_W-1:0] y;
    logic [CNT_W-1:0]        count;
    bounds_t                 bnds;
  } result_word_t;

  // one stimulus row; typed rows carry the answer fields written by hand
  typedef struct packed {
    cmd_word_t               w;
    logic                    typed;
    logic [1:0]              status;
    logic [ADDR_W-1:0]       index;
    logic signed [VAL_W-1:0] x;
    logic signed [VAL_W-1:0] y;
  } stim_row_t;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic [1:0]              cmd;
  logic signed [VAL_W-1:0] key_x;
  logic signed [VAL_W-1:0] val_y;
  logic [ADDR_W-1:0]       entry_index;
  logic                    busy;
  logic                    done;
  logic [1:0]              status;
  logic [ADDR_W-1:0]       found_index;
  logic signed [VAL_W-1:0] found_x;
  logic signed [VAL_W-1:0] found_y;
  logic [CNT_W-1:0]        entry_count;
  logic signed [VAL_W-1:0] min_x;
  logic signed [VAL_W-1:0] max_x;
  logic signed [VAL_W-1:0] min_y;
  logic signed [VAL_W-1:0] max_y;

  // mirror of the sorted table
  pair_t   sorted_pairs [CAPACITY];
  int      pairs_held;
  bounds_t pair_bounds;

  result_word_t pending_results [$];
  int           error_count;
  int           idle_cycles;
  bit           idle_free;
  bit           full_seen;

  stim_row_t directed_rows [22] = '{
    // empty table after reset
    '{'{CMD_LOOKUP, Q_ZERO, Q_ZERO, 8'd0}, 1'b1, ST_EMPTY, 8'd0, Q_ZERO, Q_ZERO},
    '{'{CMD_READ, Q_ZERO, Q_ZERO, 8'd0}, 1'b1, ST_EMPTY, 8'd0, Q_ZERO, Q_ZERO},
    '{'{CMD_UNUSED, Q_ONE, Q_TWO, 8'd5}, 1'b1, ST_OK, 8'd0, Q_ZERO, Q_ZERO},
    '{'{CMD_READ, Q_ONE, Q_ONE, 8'd255}, 1'b1, ST_EMPTY, 8'd0, Q_ZERO, Q_ZERO},
    // first inserts, one equal x
    '{'{CMD_INSERT, Q_ONE, Q_TWO, 8'd0}, 1'b1, ST_OK, 8'd0, Q_ONE, Q_TWO},
    '{'{CMD_INSERT, Q_THREE, Q_MINUS, 8'd0}, 1'b0, ST_OK, 8'd0, Q_ZERO, Q_ZERO},
    '{'{CMD_INSERT, Q_ONE, 32'sd5, 8'd0}, 1'b0, ST_OK, 8'd0, Q_ZERO, Q_ZERO},
    // floor lookups inside, below and above the x range
    '{'{CMD_LOOKUP, Q_TWO, Q_ZERO, 8'd0}, 1'b0, ST_OK, 8'd0, Q_ZERO, Q_ZERO},
    '{'{CMD_LOOKUP, -32'sd5, Q_ZERO, 8'd0}, 1'b0, ST_OK, 8'd0, Q_ZERO, Q_ZERO},
    '{'{CMD_LOOKUP, Q_THREE, Q_ZERO, 8'd0}, 1'b0, ST_OK, 8'd0, Q_ZERO, Q_ZERO},
    '{'{CMD_LOOKUP, VAL_MOST_POS, Q_ZERO, 8'd0}, 1'b0, ST_OK, 8'd0, Q_ZERO, Q_ZERO},
    // reads past the end and inside
    '{'{CMD_READ, Q_ZERO, Q_ZERO, 8'd3}, 1'b1, ST_BAD_INDEX, 8'd0, Q_ZERO, Q_ZERO},
    '{'{CMD_READ, Q_ZERO, Q_ZERO, 8'd255}, 1'b1, ST_BAD_INDEX, 8'd0, Q_ZERO, Q_ZERO},
    '{'{CMD_READ, Q_ZERO, Q_ZERO, 8'd2}, 1'b0, ST_OK, 8'd0, Q_ZERO, Q_ZERO},
    // extreme values
    '{'{CMD_INSERT, VAL_MOST_NEG, VAL_MOST_POS, 8'd0}, 1'b1, ST_OK, 8'd0, VAL_MOST_NEG,
      VAL_MOST_POS},
    '{'{CMD_INSERT, VAL_MOST_POS, VAL_MOST_NEG, 8'd0}, 1'b0, ST_OK, 8'd0, Q_ZERO, Q_ZERO},
    '{'{CMD_INSERT, VAL_MOST_POS, Q_ZERO, 8'd0}, 1'b0, ST_OK, 8'd0, Q_ZERO, Q_ZERO},
    '{'{CMD_LOOKUP, VAL_MOST_NEG, Q_ZERO, 8'd0}, 1'b0, ST_OK, 8'd0, Q_ZERO, Q_ZERO},
    '{'{CMD_LOOKUP, VAL_MOST_POS, Q_ZERO, 8'd0}, 1'b0, ST_OK, 8'd0, Q_ZERO, Q_ZERO},
    '{'{CMD_LOOKUP, Q_ONE, Q_ZERO, 8'd0}, 1'b0, ST_OK, 8'd0, Q_ZERO, Q_ZERO},
    '{'{CMD_UNUSED, Q_MINUS, Q_MINUS, 8'd255}, 1'b1, ST_OK, 8'd0, Q_ZERO, Q_ZERO},
    '{'{CMD_READ, Q_ZERO, Q_ZERO, 8'd0}, 1'b0, ST_OK, 8'd0, Q_ZERO, Q_ZERO}
  };

  sorted_pair_table_floor_lookup_core dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .cmd         (cmd),
    .key_x       (key_x),
    .val_y       (val_y),
    .entry_index (entry_index),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .found_index (found_index),
    .found_x     (found_x),
    .found_y     (found_y),
    .entry_count (entry_count),
    .min_x       (min_x),
    .max_x       (max_x),
    .min_y       (min_y),
    .max_y       (max_y)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // apply one word to the mirror table and build its answer
  task automatic table_apply(input cmd_word_t w, output result_word_t r);
    int pos;
    int hit;
    r = '0;
    r.status = ST_OK;
    case (w.op)
      CMD_INSERT: begin
        if (pairs_held >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // new pair goes ahead of every equal x
          pos = 0;
          while (pos < pairs_held && sorted_pairs[pos].x < w.kx) pos++;
          for (int j = pairs_held; j > pos; j--) sorted_pairs[j] = sorted_pairs[j-1];
          sorted_pairs[pos].x = w.kx;
          sorted_pairs[pos].y = w.vy;
          pairs_held++;
          if (w.kx < pair_bounds.min_x) pair_bounds.min_x = w.kx;
          if (w.kx > pair_bounds.max_x) pair_bounds.max_x = w.kx;
          if (w.vy < pair_bounds.min_y) pair_bounds.min_y = w.vy;
          if (w.vy > pair_bounds.max_y) pair_bounds.max_y = w.vy;
          r.index = pos[ADDR_W-1:0];
          r.x = w.kx;
          r.y = w.vy;
        end
      end
      CMD_LOOKUP: begin
        if (pairs_held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // floor search clamped to the first and last entries
          hit = pairs_held - 1;
          if (w.kx < pair_bounds.min_x) begin
            hit = 0;
          end else if (w.kx < pair_bounds.max_x) begin
            for (int i = 1; i < pairs_held; i++) begin
              if (w.kx < sorted_pairs[i].x) begin
                hit = i - 1;
                break;
              end
            end
          end
          r.index = hit[ADDR_W-1:0];
          r.x = sorted_pairs[hit].x;
          r.y = sorted_pairs[hit].y;
        end
      end
      CMD_READ: begin
        if (pairs_held == 0) begin
          r.status = ST_EMPTY;
        end else if (int'(w.idx) >= pairs_held) begin
          r.status = ST_BAD_INDEX;
        end else begin
          r.index = w.idx;
          r.x = sorted_pairs[w.idx].x;
          r.y = sorted_pairs[w.idx].y;
        end
      end
      default: ;
    endcase
    r.count = pairs_held[CNT_W-1:0];
    r.bnds = pair_bounds;
  endtask

  // hold off, present the word, wait for it to be taken, predict its answer
  task automatic send_word(input stim_row_t row, input int gap);
    result_word_t r;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    cmd <= row.w.op;
    key_x <= row.w.kx;
    val_y <= row.w.vy;
    entry_index <= row.w.idx;
    do @(posedge clk); while (busy);
    table_apply(row.w, r);
    if (row.typed) begin
      r.status = row.status;
      r.index = row.index;
      r.x = row.x;
      r.y = row.y;
    end
    pending_results.push_back(r);
    @(negedge clk);
  endtask

  // stop sending until every answer is back
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // x values: extremes, a coarse grid full of duplicates, near stored x, anything
  function automatic logic signed [VAL_W-1:0] pick_x();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return VAL_MOST_NEG;
          1: return VAL_MOST_POS;
          2: return Q_ZERO;
          default: return Q_MINUS;
        endcase
      end
      1, 2, 3: return (int'($urandom_range(0, 15)) - 8) * 65536;
      4, 5: begin
        if (pairs_held > 0)
          return sorted_pairs[$urandom_range(0, pairs_held - 1)].x
                 + (int'($urandom_range(0, 2)) - 1);
        return $urandom;
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_y();
    case ($urandom_range(0, 7))
      0: return VAL_MOST_NEG;
      1: return VAL_MOST_POS;
      default: return $urandom;
    endcase
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t row;
    int pick;
    row = '0;
    pick = $urandom_range(0, 99);
    if (pairs_held < CAPACITY)
      row.w.op = pick < 35 ? CMD_INSERT : pick < 68 ? CMD_LOOKUP :
                 pick < 95 ? CMD_READ : CMD_UNUSED;
    else
      row.w.op = pick < 15 ? CMD_INSERT : pick < 55 ? CMD_LOOKUP :
                 pick < 95 ? CMD_READ : CMD_UNUSED;
    row.w.kx = pick_x();
    row.w.vy = pick_y();
    // reads mostly land inside the table
    if (row.w.op == CMD_READ && pairs_held > 0 && $urandom_range(0, 4) != 0)
      row.w.idx = ADDR_W'($urandom_range(0, pairs_held - 1));
    else
      row.w.idx = ADDR_W'($urandom_range(0, 255));
    return row;
  endfunction

  function automatic int draw_gap();
    if ($urandom_range(0, 31) == 0) idle_free = !idle_free;
    return idle_free ? 0 : $urandom_range(0, 12);
  endfunction

  task automatic check_field(input string name, input logic [VAL_W-1:0] expv,
                             input logic [VAL_W-1:0] actv);
    if (expv !== actv) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expv, actv);
    end
  endtask

  // compare each answer word with the oldest prediction
  always @(posedge clk) begin
    result_word_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: answer word with nothing expected, expected none, actual status %0d",
                 $time, status);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(status));
        check_field("found_index", 32'(want.index), 32'(found_index));
        check_field("found_x", want.x, found_x);
        check_field("found_y", want.y, found_y);
        check_field("entry_count", 32'(want.count), 32'(entry_count));
        check_field("min_x", want.bnds.min_x, min_x);
        check_field("max_x", want.bnds.max_x, max_x);
        check_field("min_y", want.bnds.min_y, min_y);
        check_field("max_y", want.bnds.max_y, max_y);
      end
    end
  end

  // watchdog on cycles where no word moves either way
  always @(posedge clk) begin
    if (rst || (start && !busy) || done)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // main sequence
  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd = CMD_INSERT;
    key_x = '0;
    val_y = '0;
    entry_index = '0;
    error_count = 0;
    idle_cycles = 0;
    idle_free = 1'b0;
    full_seen = 1'b0;
    pairs_held = 0;
    pair_bounds = '{VAL_MOST_POS, VAL_MOST_NEG, VAL_MOST_POS, VAL_MOST_NEG};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) send_word(directed_rows[i], draw_gap());
    drain_results();

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      send_word(random_row(), draw_gap());
      // let the table settle once it first fills up
      if (!full_seen && pairs_held == CAPACITY) begin
        full_seen = 1'b1;
        drain_results();
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/spt_pkg.sv
hw/rtl/spt_bounds.sv
hw/rtl/sorted_pair_table_floor_lookup_core.sv
dv/sorted_pair_table_floor_lookup_core_test.sv
